### hdl/bwlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwlp_pkg
// Shared widths, types and register indexes for the three-channel
// second-order low-pass filter.
// ----------------------------------------------------------------------------
package bwlp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_FRAC = 16;
  localparam int CHANNELS  = 3;
  localparam int B0_W      = 17;
  localparam int A_W       = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  // x0 + 2*x1 + x2
  localparam int TAPSUM_W  = SAMPLE_W + 3;
  localparam int PROD_B_W  = B0_W + 1 + TAPSUM_W;
  localparam int PROD_A_W  = A_W + SAMPLE_W;
  localparam int ACC_W     = PROD_B_W + 1;
  localparam int SHIFT_W   = ACC_W - COEF_FRAC;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_B0     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_A1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_A2 = CFG_IDX_W'(2);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic        [B0_W-1:0] b0;
    logic signed [A_W-1:0]  a1;
    logic signed [A_W-1:0]  a2;
  } coef_t;

endpackage

### hdl/bwlp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwlp_in_if
// Sample channel: three joint torque samples per transfer.
// ----------------------------------------------------------------------------
interface bwlp_in_if import bwlp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t torque_one;
  sample_t torque_two;
  sample_t torque_three;

  modport source (output valid, torque_one, torque_two, torque_three, input ready);
  modport sink   (input valid, torque_one, torque_two, torque_three, output ready);
endinterface

### hdl/bwlp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwlp_out_if
// Result channel: three filtered torque samples per transfer.
// ----------------------------------------------------------------------------
interface bwlp_out_if import bwlp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t filtered_one;
  sample_t filtered_two;
  sample_t filtered_three;

  modport source (output valid, filtered_one, filtered_two, filtered_three, input ready);
  modport sink   (input valid, filtered_one, filtered_two, filtered_three, output ready);
endinterface

### hdl/bwlp_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwlp_cfg_if
// Coefficient write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bwlp_cfg_if import bwlp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/bwlp_coef_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwlp_coef_regs
// Coefficient register file written over the configuration channel.
// ----------------------------------------------------------------------------
module bwlp_coef_regs import bwlp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  bwlp_cfg_if.sink     cfg,
  output coef_t        coef
);

  coef_t coef_r;
  coef_t coef_nxt;

  assign cfg.ready = 1'b1;
  assign coef      = coef_r;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_GAIN_B0:     coef_nxt.b0 = cfg.data[B0_W-1:0];
        REG_FEEDBACK_A1: coef_nxt.a1 = $signed(cfg.data[A_W-1:0]);
        REG_FEEDBACK_A2: coef_nxt.a2 = $signed(cfg.data[A_W-1:0]);
        default:         coef_nxt    = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

endmodule

### hdl/bwlp_section.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwlp_section
// One direct form I biquad with taps b0, 2*b0, b0 and feedback a1, a2.
// History advances on adv; result is rounded to nearest and saturated.
// ----------------------------------------------------------------------------
module bwlp_section import bwlp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  coef_t   coef,
  input  sample_t x0,
  output sample_t y
);

  localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'((1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [SHIFT_W-1:0] SAT_LO = -SAT_HI - SHIFT_W'(1);
  localparam logic signed [ACC_W-1:0]   RND    = ACC_W'(1) <<< (COEF_FRAC - 1);

  sample_t x1_r, x2_r, y1_r, y2_r;

  logic signed [TAPSUM_W-1:0] tap_sum;
  logic signed [PROD_B_W-1:0] prod_b;
  logic signed [PROD_A_W-1:0] prod_a1;
  logic signed [PROD_A_W-1:0] prod_a2;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SHIFT_W-1:0]  scaled;

  always_comb begin
    tap_sum = TAPSUM_W'(x0) + (TAPSUM_W'(x1_r) <<< 1) + TAPSUM_W'(x2_r);
    prod_b  = $signed({1'b0, coef.b0}) * tap_sum;
    prod_a1 = coef.a1 * y1_r;
    prod_a2 = coef.a2 * y2_r;
    acc     = ACC_W'(prod_b) - ACC_W'(prod_a1) - ACC_W'(prod_a2) + RND;
    scaled  = acc[ACC_W-1:COEF_FRAC];
    priority if (scaled > SAT_HI) begin
      y = SAT_HI[SAMPLE_W-1:0];
    end else if (scaled < SAT_LO) begin
      y = SAT_LO[SAMPLE_W-1:0];
    end else begin
      y = scaled[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (adv) begin
      x1_r <= x0;
      x2_r <= x1_r;
      y1_r <= y;
      y2_r <= y1_r;
    end
  end

endmodule

### hdl/butterworth_lowpass_three_channel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// butterworth_lowpass_three_channel_unit
// Three second-order Butterworth low-pass sections, one per joint torque.
//
// in_bus  : valid/ready sink, three signed 16-bit torque samples per transfer.
// out_bus : valid/ready source, three filtered samples, rounded and saturated.
// cfg_bus : always ready; index 0 = b0, 1 = a1, 2 = a2, other indexes ignored.
//           Write only while no sample is in flight.
// Samples land in an input register; the three biquads work from it
// combinationally into the output register. Out valid rises when a set
// moves from the input register into the output register; throughput is
// one sample set per cycle while the receiver does not stall, set by the
// feedback path y[n-1] -> multiply-accumulate -> y[n] inside each section.
// A stalled receiver holds the output register; one more set may wait in the
// input register before in ready drops.
// Reset (rst_n low, synchronous) clears coefficients, filter history and
// both valid flags.
// ----------------------------------------------------------------------------
module butterworth_lowpass_three_channel_unit import bwlp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bwlp_in_if.sink     in_bus,
  bwlp_out_if.source  out_bus,
  bwlp_cfg_if.sink    cfg_bus
);

  coef_t   coef;
  logic    s1_valid_r;
  sample_t s1_x_r [CHANNELS];
  sample_t y      [CHANNELS];
  logic    out_valid_r;
  sample_t out_y_r [CHANNELS];
  logic    adv;
  logic    in_xfer;

  assign adv           = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready  = !s1_valid_r || adv;
  assign in_xfer       = in_bus.valid && in_bus.ready;

  bwlp_coef_regs u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_bus),
    .coef  (coef)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    bwlp_section u_sec (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .coef  (coef),
      .x0    (s1_x_r[c]),
      .y     (y[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x_r[0] <= in_bus.torque_one;
      s1_x_r[1] <= in_bus.torque_two;
      s1_x_r[2] <= in_bus.torque_three;
    end
    if (adv) begin
      out_y_r <= y;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.filtered_one   = out_y_r[0];
  assign out_bus.filtered_two   = out_y_r[1];
  assign out_bus.filtered_three = out_y_r[2];

endmodule

### tb/tb_butterworth_lowpass_three_channel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_butterworth_lowpass_three_channel_unit
// Self-checking bench for the three-channel low-pass biquad unit. A directed
// table covers the register reset values, sample extremes, saturation,
// rounding ties and odd coefficient patterns. Random phases with fresh
// coefficients follow. Every result transfer is compared against the table's
// expected values or an internal fixed-point filter model. Both channels
// throttle at random.
module tb_butterworth_lowpass_three_channel_unit;
  import bwlp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_SETTLE  = 4;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 235;
  localparam int QUIET_FROM    = 1580;
  localparam int LONG_HOLD     = 64;
  localparam int ROWS          = 34;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  // Butterworth sections at fc/fs = 0.1, 0.25, 0.02, 0.4
  localparam int BW_B0 [4] = '{4421, 19195, 237, 41874};
  localparam int BW_A1 [4] = '{-74907, 0, -119452, 74907};
  localparam int BW_A2 [4] = '{27053, 11244, 54865, 27053};

  localparam int EDGE_VALUES [5] = '{32767, -32768, 0, -1, 1};

  typedef struct packed {
    sample_t one;
    sample_t two;
    sample_t three;
  } joint_set_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_KNOWN, ROW_PREDICT} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    joint_set_t           smp;
    joint_set_t           want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  bwlp_in_if  in_bus ();
  bwlp_out_if out_bus ();
  bwlp_cfg_if cfg_bus ();

  butterworth_lowpass_three_channel_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  row_t directed_rows [ROWS] = '{
    '{ROW_KNOWN,   REG_GAIN_B0,     18'h00000, '{32767, -32768, 0},    '{0, 0, 0}},
    '{ROW_KNOWN,   REG_GAIN_B0,     18'h00000, '{-32768, 32767, -1},   '{0, 0, 0}},
    '{ROW_KNOWN,   REG_GAIN_B0,     18'h00000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_KNOWN,   REG_GAIN_B0,     18'h00000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_WRITE,   REG_UNUSED,      18'h3FFFF, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_WRITE,   REG_GAIN_B0,     18'h10000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_KNOWN,   REG_GAIN_B0,     18'h00000, '{32767, -32768, 1},    '{32767, -32768, 1}},
    '{ROW_KNOWN,   REG_GAIN_B0,     18'h00000, '{32767, -32768, 0},    '{32767, -32768, 2}},
    '{ROW_KNOWN,   REG_GAIN_B0,     18'h00000, '{0, 0, 0},             '{32767, -32768, 1}},
    '{ROW_KNOWN,   REG_GAIN_B0,     18'h00000, '{0, 0, 0},             '{32767, -32768, 0}},
    '{ROW_KNOWN,   REG_GAIN_B0,     18'h00000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_WRITE,   REG_GAIN_B0,     18'h08000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{1, -1, 3},            '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{-3, 5, -32768},       '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{2, -2, 7},            '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_WRITE,   REG_FEEDBACK_A1, 18'h20000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_WRITE,   REG_FEEDBACK_A2, 18'h10000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{1000, -1000, 32767},  '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{-32768, 32767, 12345}, '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_WRITE,   REG_GAIN_B0,     18'h1FFFF, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_WRITE,   REG_FEEDBACK_A1, 18'h1FFFF, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_WRITE,   REG_FEEDBACK_A2, 18'h30000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{32767, -32768, -1},   '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{-1, 1, 0},            '{0, 0, 0}},
    '{ROW_WRITE,   REG_FEEDBACK_A2, 18'h20000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{100, -100, 5},        '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_WRITE,   REG_FEEDBACK_A1, 18'h00000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_WRITE,   REG_FEEDBACK_A2, 18'h00000, '{0, 0, 0},             '{0, 0, 0}},
    '{ROW_PREDICT, REG_GAIN_B0,     18'h00000, '{-32768, -32768, 32767}, '{0, 0, 0}}
  };

  // filter model state
  logic        [B0_W-1:0] coef_b0 = '0;
  logic signed [A_W-1:0]  coef_a1 = '0;
  logic signed [A_W-1:0]  coef_a2 = '0;
  sample_t hist_x1 [CHANNELS] = '{default: '0};
  sample_t hist_x2 [CHANNELS] = '{default: '0};
  sample_t hist_y1 [CHANNELS] = '{default: '0};
  sample_t hist_y2 [CHANNELS] = '{default: '0};

  joint_set_t pending_filtered [$];
  int         walk [CHANNELS] = '{default: 0};
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         quiet;
  bit         hold_req;
  bit         hold_taken = 1'b0;
  int         stall_left = 0;

  function automatic sample_t biquad_step(int ch, sample_t x0);
    longint acc;
    acc = longint'(coef_b0) * (longint'(x0) + 2 * longint'(hist_x1[ch])
          + longint'(hist_x2[ch]))
          - longint'(coef_a1) * longint'(hist_y1[ch])
          - longint'(coef_a2) * longint'(hist_y2[ch]);
    acc = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    if (acc > SAT_HI) begin
      acc = SAT_HI;
    end else if (acc < SAT_LO) begin
      acc = SAT_LO;
    end
    hist_x2[ch] = hist_x1[ch];
    hist_x1[ch] = x0;
    hist_y2[ch] = hist_y1[ch];
    hist_y1[ch] = sample_t'(acc);
    return sample_t'(acc);
  endfunction

  function automatic joint_set_t run_biquads(joint_set_t s);
    joint_set_t r;
    r.one   = biquad_step(0, s.one);
    r.two   = biquad_step(1, s.two);
    r.three = biquad_step(2, s.three);
    return r;
  endfunction

  function automatic sample_t draw_torque(int ch);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        walk[ch] = walk[ch] + int'($urandom_range(0, 2000)) - 1000;
        if (walk[ch] > 32767) walk[ch] = 32767;
        if (walk[ch] < -32768) walk[ch] = -32768;
        return sample_t'(walk[ch]);
      end
      4, 5, 6: return sample_t'($urandom);
      7, 8:    return sample_t'(EDGE_VALUES[$urandom_range(0, 4)]);
      default: return sample_t'(int'($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_GAIN_B0:     coef_b0 = data[B0_W-1:0];
      REG_FEEDBACK_A1: coef_a1 = data[A_W-1:0];
      REG_FEEDBACK_A2: coef_a2 = data[A_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_coefficients();
    logic [CFG_DAT_W-1:0] b0;
    logic [CFG_DAT_W-1:0] a1;
    logic [CFG_DAT_W-1:0] a2;
    int set;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        set = $urandom_range(0, 3);
        b0  = CFG_DAT_W'(BW_B0[set]);
        a1  = CFG_DAT_W'(BW_A1[set]);
        a2  = CFG_DAT_W'(BW_A2[set]);
      end
      3: begin
        b0 = CFG_DAT_W'($urandom_range(0, 65536));
        a1 = CFG_DAT_W'($urandom_range(0, 262143));
        a2 = CFG_DAT_W'(int'($urandom_range(0, 131072)) - 65536);
      end
      4: begin
        b0 = CFG_DAT_W'($urandom);
        a1 = CFG_DAT_W'($urandom);
        a2 = CFG_DAT_W'($urandom);
      end
      default: begin
        b0 = $urandom_range(0, 1) ? 18'h10000 : 18'h00000;
        a1 = $urandom_range(0, 1) ? 18'h20000 : 18'h1FFFF;
        a2 = $urandom_range(0, 1) ? 18'h10000 : 18'h30000;
      end
    endcase
    write_coef(REG_GAIN_B0, b0);
    write_coef(REG_FEEDBACK_A1, a1);
    write_coef(REG_FEEDBACK_A2, a2);
    if ($urandom_range(0, 3) == 0) write_coef(REG_UNUSED, CFG_DAT_W'($urandom));
  endtask

  task automatic send_set(joint_set_t s, bit known, joint_set_t want);
    joint_set_t got;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.torque_one   <= s.one;
    in_bus.torque_two   <= s.two;
    in_bus.torque_three <= s.three;
    do @(posedge clk); while (!in_bus.ready);
    got = run_biquads(s);
    pending_filtered.insert(pending_filtered.size(), known ? want : got);
  endtask

  task automatic compare_field(string name, sample_t want, sample_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result sink: short random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      stall_left    <= LONG_HOLD - 1;
      out_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 3);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    joint_set_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_filtered.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = pending_filtered.pop_front();
        compare_field("filtered_one", want.one, out_bus.filtered_one);
        compare_field("filtered_two", want.two, out_bus.filtered_two);
        compare_field("filtered_three", want.three, out_bus.filtered_three);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_butterworth_lowpass_three_channel_unit failed");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    quiet               = 1'b0;
    hold_req            = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.torque_one   = '0;
    in_bus.torque_two   = '0;
    in_bus.torque_three = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = '0;
    cfg_bus.data        = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_WRITE: write_coef(directed_rows[i].idx, directed_rows[i].data);
        ROW_KNOWN: send_set(directed_rows[i].smp, 1'b1, directed_rows[i].want);
        default:   send_set(directed_rows[i].smp, 1'b0, directed_rows[i].want);
      endcase
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_coefficients();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph * PHASE_ITEMS + n == QUIET_FROM) quiet = 1'b1;
        if (ph == 1 && n == 100) hold_req = 1'b1;
        if (ph == 3 && n == 100) wait_drained();
        send_set(joint_set_t'{draw_torque(0), draw_torque(1), draw_torque(2)},
                 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("tb_butterworth_lowpass_three_channel_unit passed");
    end else begin
      $display("tb_butterworth_lowpass_three_channel_unit failed");
    end
    $finish;
  end

endmodule
